// ===== rtl/spet_pkg.sv =====
// Shared constants and controller-to-datapath command type for the sparse entry table.
package spet_pkg;

  // Default configuration of the table.
  localparam int CapacityDefault  = 64;
  localparam int KeyBitsDefault   = 16;
  localparam int ValueBitsDefault = 32;

  // Fixed widths of the request and result fields.
  localparam int ActionW = 2;
  localparam int IndexW  = 16;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  // Request actions.
  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_READ   = 2'd1;
  localparam logic [ActionW-1:0] ACT_DELETE = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatusW-1:0] ST_PRESENT = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd2;
  localparam logic [StatusW-1:0] ST_ABSENT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // write an invalid word at the sweep address
    logic latch;   // capture the request and reset the search flags
    logic rd;      // read the slot at the sweep address
    logic commit;  // update the table and load the result register
  } dp_cmd_t;

endpackage

// ===== rtl/spet_ctrl.sv =====
// Controller state machine: clearing pass, request acceptance, slot sweep and commit.
module spet_ctrl #(
  parameter int CAPACITY = spet_pkg::CapacityDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        res_free,
  output spet_pkg::dp_cmd_t           cmd,
  output logic [$clog2(CAPACITY)-1:0] addr
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  // Next state and sweep counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastIdx) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastIdx) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Commands decoded from the current state.
  assign in_ready   = (state_r == S_IDLE);
  assign addr       = cnt_r;
  assign cmd.clr    = (state_r == S_CLEAR);
  assign cmd.latch  = (state_r == S_IDLE) && in_valid;
  assign cmd.rd     = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && res_free;

endmodule

// ===== rtl/spet_dp.sv =====
// Datapath: slot memory, key compare, free-slot tracking, live count and result register.
module spet_dp #(
  parameter int CAPACITY   = spet_pkg::CapacityDefault,
  parameter int KEY_BITS   = spet_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = spet_pkg::ValueBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spet_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(CAPACITY)-1:0]       addr,
  input  logic [spet_pkg::ActionW-1:0]      in_action,
  input  logic [spet_pkg::IndexW-1:0]       in_row_index,
  input  logic [spet_pkg::IndexW-1:0]       in_col_index,
  input  logic [spet_pkg::DataW-1:0]        in_value,
  output logic                              res_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spet_pkg::DataW-1:0]        out_read_value,
  output logic [spet_pkg::StatusW-1:0]      out_status,
  output logic [spet_pkg::CountW-1:0]       out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = 1 + 2 * KEY_BITS + VALUE_BITS;

  // Slot memory: {valid, row, column, data} per slot.
  logic [WW-1:0] mem [CAPACITY];
  logic [WW-1:0] rd_word_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  // Captured request.
  logic [spet_pkg::ActionW-1:0] req_act_r;
  logic [KEY_BITS-1:0]          req_row_r;
  logic [KEY_BITS-1:0]          req_col_r;
  logic [VALUE_BITS-1:0]        req_data_r;

  // Search state.
  logic                  rd_pend_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  hit_r;
  logic [AW-1:0]         hit_idx_r;
  logic [VALUE_BITS-1:0] hit_data_r;
  logic                  free_r;
  logic [AW-1:0]         free_idx_r;
  logic [CW-1:0]         count_r;

  // Result register.
  logic                         out_valid_r;
  logic [spet_pkg::DataW-1:0]   out_rv_r;
  logic [spet_pkg::StatusW-1:0] out_st_r;
  logic [spet_pkg::CountW-1:0]  out_cnt_r;

  // Fields of the word just read.
  logic                  w_valid;
  logic [KEY_BITS-1:0]   w_row;
  logic [KEY_BITS-1:0]   w_col;
  logic [VALUE_BITS-1:0] w_data;

  assign w_valid = rd_word_r[WW-1];
  assign w_row   = rd_word_r[WW-2 -: KEY_BITS];
  assign w_col   = rd_word_r[WW-2-KEY_BITS -: KEY_BITS];
  assign w_data  = rd_word_r[VALUE_BITS-1:0];

  // Outcome of the request once the sweep is complete.
  logic                         do_ins;
  logic                         do_del;
  logic [spet_pkg::StatusW-1:0] res_st;
  logic [spet_pkg::DataW-1:0]   res_rv;
  logic [CW-1:0]                count_nxt;

  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    res_st    = spet_pkg::ST_DONE;
    res_rv    = '0;
    count_nxt = count_r;
    case (req_act_r)
      spet_pkg::ACT_INSERT: begin
        if (hit_r) begin
          res_st = spet_pkg::ST_PRESENT;
        end else if (!free_r) begin
          res_st = spet_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      spet_pkg::ACT_READ: begin
        if (hit_r) begin
          res_rv = spet_pkg::DataW'(hit_data_r);
        end else begin
          res_st = spet_pkg::ST_ABSENT;
        end
      end
      spet_pkg::ACT_DELETE: begin
        if (hit_r) begin
          do_del    = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          res_st = spet_pkg::ST_ABSENT;
        end
      end
      default: begin
        res_st = spet_pkg::ST_DONE;
      end
    endcase
  end

  // Memory write port: clearing pass, insert into the free slot, or delete at the hit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.commit && do_ins) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx_r;
      mem_wdata = {1'b1, req_row_r, req_col_r, req_data_r};
    end else if (cmd.commit && do_del) begin
      mem_we    = 1'b1;
      mem_waddr = hit_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_word_r <= mem[addr];
    end
  end

  // Request capture and search results.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_act_r  <= in_action;
      req_row_r  <= KEY_BITS'(in_row_index);
      req_col_r  <= KEY_BITS'(in_col_index);
      req_data_r <= VALUE_BITS'(in_value);
    end
    if (cmd.rd) begin
      rd_idx_r <= addr;
    end
    if (rd_pend_r && !hit_r && w_valid && w_row == req_row_r && w_col == req_col_r) begin
      hit_idx_r  <= rd_idx_r;
      hit_data_r <= w_data;
    end
    if (rd_pend_r && !free_r && !w_valid) begin
      free_idx_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      rd_pend_r <= cmd.rd;
      if (cmd.latch) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (rd_pend_r) begin
        if (w_valid && w_row == req_row_r && w_col == req_col_r) begin
          hit_r <= 1'b1;
        end
        if (!w_valid) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result register: loaded at commit, emptied by an output transfer.
  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_rv_r  <= res_rv;
      out_st_r  <= res_st;
      out_cnt_r <= spet_pkg::CountW'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rv_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

`ifndef SYNTHESIS
  // The live count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("live count above capacity");

  // A successful insert raises the live count by one.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && do_ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not raise the live count");

  // A successful delete lowers the live count by one.
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && do_del |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not lower the live count");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
`endif

endmodule

// ===== rtl/sparse_entry_table.sv =====
// Top level of the sparse entry table: controller and datapath.
//
// Usage: an associative store of sparse matrix entries keyed by (row, column).
// The request channel (in_valid/in_ready) carries an action (insert, read or
// delete), the key and, for an insert, the value. Each request produces one
// result on the out_valid/out_ready channel: the read value, a status code
// and the live entry count after the request.
// Each request sweeps every slot through the single read port of the slot
// memory, one slot per cycle. After the sweep the controller passes a drain
// state and then commits, loading the result register; a new request is
// taken only once the controller is back in idle after that commit.
// A finished result waits in the output register; the next request is taken
// and swept while it waits, and only the commit of that next request stalls
// until the receiver takes the earlier result.
// After reset the table runs a clearing pass over every slot, one slot a
// cycle, with in_ready low; then the table is empty and the count is zero.
module sparse_entry_table #(
  parameter int CAPACITY   = spet_pkg::CapacityDefault,
  parameter int KEY_BITS   = spet_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = spet_pkg::ValueBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spet_pkg::ActionW-1:0] in_action,
  input  logic [spet_pkg::IndexW-1:0]  in_row_index,
  input  logic [spet_pkg::IndexW-1:0]  in_col_index,
  input  logic [spet_pkg::DataW-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spet_pkg::DataW-1:0]   out_read_value,
  output logic [spet_pkg::StatusW-1:0] out_status,
  output logic [spet_pkg::CountW-1:0]  out_entry_count
);

  spet_pkg::dp_cmd_t             cmd;
  logic [$clog2(CAPACITY)-1:0]   addr;
  logic                          res_free;

  // Sequencer.
  spet_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .res_free (res_free),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Slot memory and compare logic.
  spet_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .in_action       (in_action),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value        (in_value),
    .res_free        (res_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
